// File: sv/ppt_pkg.sv
// Shared types, constants and helpers for the projection point transform.
package ppt_pkg;

  // datapath widths
  localparam int LANES = 3;
  localparam int MAG_W = 64;            // magnitude of a, b, d
  localparam int SV_W = 66;             // signed working width
  localparam int DEN_W = 96;            // widest divisor magnitude
  localparam int QB = 34;               // quotient bits kept before clamping
  localparam int QW = QB + 2;           // signed lane quotient width
  localparam int FRONT_STAGES = 5;
  localparam int DIV_STAGES = QB + 2;
  localparam int LATENCY = FRONT_STAGES + DIV_STAGES + 1;
  localparam int NUM_REGS = 8;
  localparam int ADDR_W = 5;

  // lane indexes
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  typedef enum logic [2:0] {
    CMD_PROJ_DIV     = 3'd0,
    CMD_PROJ_HOM     = 3'd1,
    CMD_DEPTH_UNPROJ = 3'd2,
    CMD_HOM_UNPROJ   = 3'd3,
    CMD_UNPROJ_PT    = 3'd4
  } ppt_cmd_t;

  typedef enum logic [2:0] {
    REG_SCALE_X  = 3'd0,
    REG_SCALE_Y  = 3'd1,
    REG_SCALE_Z  = 3'd2,
    REG_RATIO_X  = 3'd3,
    REG_RATIO_Y  = 3'd4,
    REG_OFFSET_X = 3'd5,
    REG_OFFSET_Y = 3'd6,
    REG_OFFSET_Z = 3'd7
  } ppt_reg_t;

  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] ratio_x;
    logic signed [31:0] ratio_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
  } ppt_cfg_t;

  // per-item info that rides alongside the divider lanes
  typedef struct packed {
    logic                   x_lane;   // x_out from lane X
    logic                   y_lane;   // y_out from lane Y
    logic                   z_lane;   // z_out from lane Z
    logic                   w_lane;   // w_out from lane Z
    logic signed [SV_W-1:0] x_dir;
    logic signed [SV_W-1:0] y_dir;
    logic signed [SV_W-1:0] z_dir;
    logic signed [SV_W-1:0] w_dir;
    logic signed [31:0]     x_sub;
    logic signed [31:0]     y_sub;
    logic signed [31:0]     z_sub;
    logic                   div_zero;
  } ppt_side_t;

  function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    smul = a * b;
  endfunction

  function automatic logic [63:0] umul(input logic [31:0] a, input logic [31:0] b);
    umul = a * b;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    mag32 = a[31] ? 32'(-a) : 32'(a);
  endfunction

endpackage

// File: sv/ppt_front.sv
// Front stages: products, sums, command decode and divider operand setup.
module ppt_front #(
  parameter int FRAC_BITS = 16,
  parameter int NUM_W = ppt_pkg::DEN_W + FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [2:0]                 cmd,
  input  logic                       perspective,
  input  logic signed [31:0]         x_in,
  input  logic signed [31:0]         y_in,
  input  logic signed [31:0]         z_in,
  input  logic signed [31:0]         w_in,
  input  ppt_pkg::ppt_cfg_t          cfg,
  output logic                       out_valid,
  output logic [NUM_W-1:0]           lane_num [ppt_pkg::LANES],
  output logic [ppt_pkg::DEN_W-1:0]  lane_den [ppt_pkg::LANES],
  output logic                       lane_neg [ppt_pkg::LANES],
  output logic                       lane_nzero [ppt_pkg::LANES],
  output ppt_pkg::ppt_side_t         side
);
  import ppt_pkg::*;

  localparam logic signed [SV_W-1:0] ONE_V = SV_W'(1) <<< FRAC_BITS;

  function automatic logic [SV_W-1:0] sv_mag(input logic signed [SV_W-1:0] v);
    sv_mag = v[SV_W-1] ? SV_W'(-v) : SV_W'(v);
  endfunction

  // stage 1: input register
  logic               v1;
  logic [2:0]         s1_cmd;
  logic               s1_persp;
  logic signed [31:0] s1_x, s1_y, s1_z, s1_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    s1_cmd   <= cmd;
    s1_persp <= perspective;
    s1_x     <= x_in;
    s1_y     <= y_in;
    s1_z     <= z_in;
    s1_w     <= w_in;
  end

  // stage 2: the 32x32 products of the scale and ratio terms with the coordinates
  logic               v2;
  logic [2:0]         s2_cmd;
  logic               s2_persp;
  logic signed [31:0] s2_x, s2_y, s2_z, s2_w;
  logic signed [63:0] s2_pxx, s2_pyy, s2_pzz, s2_prxz, s2_pryz, s2_prxw, s2_pryw, s2_pzw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2_cmd   <= s1_cmd;
    s2_persp <= s1_persp;
    s2_x     <= s1_x;
    s2_y     <= s1_y;
    s2_z     <= s1_z;
    s2_w     <= s1_w;
    s2_pxx   <= smul(cfg.scale_x, s1_x);
    s2_pyy   <= smul(cfg.scale_y, s1_y);
    s2_pzz   <= smul(cfg.scale_z, s1_z);
    s2_prxz  <= smul(cfg.ratio_x, s1_z);
    s2_pryz  <= smul(cfg.ratio_y, s1_z);
    s2_prxw  <= smul(cfg.ratio_x, s1_w);
    s2_pryw  <= smul(cfg.ratio_y, s1_w);
    s2_pzw   <= smul(cfg.scale_z, s1_w);
  end

  // stage 3: sums and command decode
  logic signed [SV_W-1:0] a_v, b_v, d_v;
  ppt_side_t              c3_side;
  logic signed [SV_W-1:0] c3_num [LANES];
  logic signed [SV_W-1:0] c3_den [LANES];
  logic [LANES-1:0]       c3_act;
  logic                   c3_force, c3_c4;

  assign a_v = (SV_W'(s2_x) <<< FRAC_BITS) + SV_W'(s2_prxw);
  assign b_v = (SV_W'(s2_y) <<< FRAC_BITS) + SV_W'(s2_pryw);
  assign d_v = (SV_W'(s2_z) <<< FRAC_BITS) + SV_W'(s2_pzw);

  always_comb begin
    c3_side  = '0;
    c3_act   = '0;
    c3_force = 1'b0;
    c3_c4    = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      c3_num[i] = '0;
      c3_den[i] = SV_W'(1);
    end
    unique case (s2_cmd)
      CMD_PROJ_DIV, CMD_PROJ_HOM: begin
        if (!s2_persp) begin
          c3_side.x_dir = (SV_W'(s2_pxx) >>> FRAC_BITS) + SV_W'(cfg.offset_x);
          c3_side.y_dir = (SV_W'(s2_pyy) >>> FRAC_BITS) + SV_W'(cfg.offset_y);
          c3_side.z_dir = (SV_W'(s2_pzz) >>> FRAC_BITS) + SV_W'(cfg.offset_z);
          c3_side.w_dir = (s2_cmd == CMD_PROJ_HOM) ? ONE_V : '0;
        end else if (s2_cmd == CMD_PROJ_HOM) begin
          c3_side.x_dir = (SV_W'(s2_pxx) + SV_W'(s2_prxz)) >>> FRAC_BITS;
          c3_side.y_dir = (SV_W'(s2_pyy) + SV_W'(s2_pryz)) >>> FRAC_BITS;
          c3_side.z_dir = SV_W'(cfg.offset_z) + (SV_W'(s2_pzz) >>> FRAC_BITS);
          c3_side.w_dir = -SV_W'(s2_z);
        end else begin
          // perspective divide by z
          c3_act         = '1;
          c3_side.x_lane = 1'b1;
          c3_side.y_lane = 1'b1;
          c3_side.z_lane = 1'b1;
          c3_side.x_sub  = cfg.ratio_x;
          c3_side.y_sub  = cfg.ratio_y;
          c3_side.z_sub  = cfg.scale_z;
          c3_num[LANE_X] = -SV_W'(s2_pxx);
          c3_num[LANE_Y] = -SV_W'(s2_pyy);
          c3_num[LANE_Z] = -(SV_W'(cfg.offset_z) <<< FRAC_BITS);
          c3_den[LANE_X] = SV_W'(s2_z);
          c3_den[LANE_Y] = SV_W'(s2_z);
          c3_den[LANE_Z] = SV_W'(s2_z);
        end
      end
      CMD_DEPTH_UNPROJ: begin
        c3_act[LANE_Z] = 1'b1;
        c3_side.z_lane = 1'b1;
        if (s2_persp) begin
          c3_num[LANE_Z] = -(SV_W'(cfg.offset_z) <<< FRAC_BITS);
          c3_den[LANE_Z] = SV_W'(s2_z) + SV_W'(cfg.scale_z);
        end else begin
          c3_num[LANE_Z] = (SV_W'(s2_z) - SV_W'(cfg.offset_z)) <<< FRAC_BITS;
          c3_den[LANE_Z] = SV_W'(cfg.scale_z);
        end
      end
      CMD_HOM_UNPROJ, CMD_UNPROJ_PT: begin
        c3_act         = '1;
        c3_side.x_lane = 1'b1;
        c3_side.y_lane = 1'b1;
        if (!s2_persp) begin
          c3_side.z_lane = 1'b1;
          c3_num[LANE_X] = (SV_W'(s2_x) - SV_W'(cfg.offset_x)) <<< FRAC_BITS;
          c3_num[LANE_Y] = (SV_W'(s2_y) - SV_W'(cfg.offset_y)) <<< FRAC_BITS;
          c3_num[LANE_Z] = (SV_W'(s2_z) - SV_W'(cfg.offset_z)) <<< FRAC_BITS;
          c3_den[LANE_X] = SV_W'(cfg.scale_x);
          c3_den[LANE_Y] = SV_W'(cfg.scale_y);
          c3_den[LANE_Z] = SV_W'(cfg.scale_z);
          if (s2_cmd == CMD_HOM_UNPROJ) begin
            c3_side.w_dir = ONE_V;
            c3_force = (cfg.scale_x == 0) || (cfg.scale_y == 0) || (cfg.scale_z == 0);
          end
        end else if (s2_cmd == CMD_HOM_UNPROJ) begin
          // lane Z carries w; z is just -w
          c3_side.w_lane = 1'b1;
          c3_side.z_dir  = -SV_W'(s2_w);
          c3_num[LANE_X] = a_v;
          c3_num[LANE_Y] = b_v;
          c3_num[LANE_Z] = d_v;
          c3_den[LANE_X] = SV_W'(cfg.scale_x);
          c3_den[LANE_Y] = SV_W'(cfg.scale_y);
          c3_den[LANE_Z] = SV_W'(cfg.offset_z);
          c3_force = (cfg.scale_x == 0) || (cfg.scale_y == 0) || (cfg.offset_z == 0);
        end else begin
          // full unproject: operands built from wide products next stages
          c3_side.z_lane = 1'b1;
          c3_c4          = 1'b1;
          c3_force = (cfg.scale_x == 0) || (cfg.scale_y == 0) || (d_v == 0);
        end
      end
      default: begin
      end
    endcase
  end

  logic                   v3;
  ppt_side_t              s3_side;
  logic signed [SV_W-1:0] s3_num [LANES];
  logic signed [SV_W-1:0] s3_den [LANES];
  logic [LANES-1:0]       s3_act;
  logic                   s3_force, s3_c4;
  logic [MAG_W-1:0]       s3_amag, s3_bmag, s3_dmag;
  logic [31:0]            s3_wmag;
  logic                   s3_asgn, s3_bsgn, s3_wsgn, s3_dsgn;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3_side  <= c3_side;
    s3_num   <= c3_num;
    s3_den   <= c3_den;
    s3_act   <= c3_act;
    s3_force <= c3_force;
    s3_c4    <= c3_c4;
    s3_amag  <= MAG_W'(sv_mag(a_v));
    s3_bmag  <= MAG_W'(sv_mag(b_v));
    s3_dmag  <= MAG_W'(sv_mag(d_v));
    s3_wmag  <= mag32(s2_w);
    s3_asgn  <= a_v[SV_W-1];
    s3_bsgn  <= b_v[SV_W-1];
    s3_wsgn  <= !s2_w[31];
    s3_dsgn  <= d_v[SV_W-1];
  end

  // stage 4: partial products of the full unproject operands
  logic                   v4;
  ppt_side_t              s4_side;
  logic signed [SV_W-1:0] s4_num [LANES];
  logic signed [SV_W-1:0] s4_den [LANES];
  logic [LANES-1:0]       s4_act;
  logic                   s4_force, s4_c4;
  logic                   s4_asgn, s4_bsgn, s4_wsgn, s4_dsgn;
  logic [MAG_W-1:0]       s4_dmag;
  logic [63:0]            s4_pa_lo, s4_pa_hi, s4_pb_lo, s4_pb_hi, s4_pw;
  logic [63:0]            s4_px_lo, s4_px_hi, s4_py_lo, s4_py_hi;
  logic [31:0]            kzm, sxm, sym;

  assign kzm = mag32(cfg.offset_z);
  assign sxm = mag32(cfg.scale_x);
  assign sym = mag32(cfg.scale_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    s4_side  <= s3_side;
    s4_num   <= s3_num;
    s4_den   <= s3_den;
    s4_act   <= s3_act;
    s4_force <= s3_force;
    s4_c4    <= s3_c4;
    s4_asgn  <= s3_asgn;
    s4_bsgn  <= s3_bsgn;
    s4_wsgn  <= s3_wsgn;
    s4_dsgn  <= s3_dsgn;
    s4_dmag  <= s3_dmag;
    s4_pa_lo <= umul(kzm, s3_amag[31:0]);
    s4_pa_hi <= umul(kzm, s3_amag[63:32]);
    s4_pb_lo <= umul(kzm, s3_bmag[31:0]);
    s4_pb_hi <= umul(kzm, s3_bmag[63:32]);
    s4_pw    <= umul(kzm, s3_wmag);
    s4_px_lo <= umul(sxm, s3_dmag[31:0]);
    s4_px_hi <= umul(sxm, s3_dmag[63:32]);
    s4_py_lo <= umul(sym, s3_dmag[31:0]);
    s4_py_hi <= umul(sym, s3_dmag[63:32]);
  end

  // stage 5: merge partials, select operands, signs and zero-divisor flag
  logic [DEN_W-1:0] na, nb, dx, dy;
  logic [NUM_W-1:0] c5_num [LANES];
  logic [DEN_W-1:0] c5_den [LANES];
  logic             c5_neg [LANES];
  logic             c5_nz [LANES];
  logic [NUM_W-1:0] c4_num [LANES];
  logic [DEN_W-1:0] c4_den [LANES];
  logic             c4_nsg [LANES];
  logic             c4_dsg [LANES];
  logic             c5_dz;
  ppt_side_t        c5_side;

  assign na = {s4_pa_hi, 32'b0} + DEN_W'(s4_pa_lo);
  assign nb = {s4_pb_hi, 32'b0} + DEN_W'(s4_pb_lo);
  assign dx = {s4_px_hi, 32'b0} + DEN_W'(s4_px_lo);
  assign dy = {s4_py_hi, 32'b0} + DEN_W'(s4_py_lo);

  always_comb begin
    c4_num[LANE_X] = NUM_W'(na) << FRAC_BITS;
    c4_num[LANE_Y] = NUM_W'(nb) << FRAC_BITS;
    c4_num[LANE_Z] = NUM_W'(s4_pw) << FRAC_BITS;
    c4_den[LANE_X] = dx;
    c4_den[LANE_Y] = dy;
    c4_den[LANE_Z] = DEN_W'(s4_dmag);
    c4_nsg[LANE_X] = cfg.offset_z[31] ^ s4_asgn;
    c4_nsg[LANE_Y] = cfg.offset_z[31] ^ s4_bsgn;
    c4_nsg[LANE_Z] = cfg.offset_z[31] ^ s4_wsgn;
    c4_dsg[LANE_X] = cfg.scale_x[31] ^ s4_dsgn;
    c4_dsg[LANE_Y] = cfg.scale_y[31] ^ s4_dsgn;
    c4_dsg[LANE_Z] = s4_dsgn;
    c5_dz = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      logic nsg, dsg, dzero;
      if (s4_c4) begin
        c5_num[i] = c4_num[i];
        c5_den[i] = c4_den[i];
        nsg = c4_nsg[i];
        dsg = c4_dsg[i];
      end else begin
        c5_num[i] = NUM_W'(sv_mag(s4_num[i]));
        c5_den[i] = DEN_W'(sv_mag(s4_den[i]));
        nsg = s4_num[i][SV_W-1];
        dsg = s4_den[i][SV_W-1];
      end
      if (s4_force) c5_den[i] = '0;
      if (!s4_act[i]) c5_num[i] = '0;
      dzero = (c5_den[i] == '0);
      // with a zero divisor the clamp takes the numerator's sign
      c5_neg[i] = dzero ? nsg : (nsg ^ dsg);
      c5_nz[i] = (c5_num[i] == '0);
      c5_dz = c5_dz | (s4_act[i] & dzero);
    end
    c5_side = s4_side;
    c5_side.div_zero = c5_dz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v4;
    end
    lane_num   <= c5_num;
    lane_den   <= c5_den;
    lane_neg   <= c5_neg;
    lane_nzero <= c5_nz;
    side       <= c5_side;
  end

endmodule

// File: sv/ppt_div.sv
// One divider lane: pipelined restoring division, one quotient bit per stage.
module ppt_div #(
  parameter int NUM_W = 112
) (
  input  logic                              clk,
  input  logic [NUM_W-1:0]                  num,
  input  logic [ppt_pkg::DEN_W-1:0]         den,
  input  logic                              neg,
  input  logic                              nzero,
  output logic signed [ppt_pkg::QW-1:0]     quo
);
  import ppt_pkg::*;

  localparam int CMP_W = DEN_W + QB;

  logic [CMP_W-1:0] rem_q  [QB+1];
  logic [QB-1:0]    quo_q  [QB+1];
  logic [DEN_W-1:0] den_q  [QB+1];
  logic             over_q [QB+1];
  logic             neg_q  [QB+1];
  logic             nz_q   [QB+1];

  // stage 0: quotient at or above 2^QB always clamps
  always_ff @(posedge clk) begin
    rem_q[0]  <= CMP_W'(num);
    quo_q[0]  <= '0;
    den_q[0]  <= den;
    over_q[0] <= CMP_W'(num) >= {den, QB'(0)};
    neg_q[0]  <= neg;
    nz_q[0]   <= nzero;
  end

  // one compare-subtract per stage, MSB first
  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int B = QB - k;
    logic [CMP_W-1:0] sh;
    logic             ge;
    assign sh = CMP_W'(den_q[k-1]) << B;
    assign ge = rem_q[k-1] >= sh;
    always_ff @(posedge clk) begin
      rem_q[k]  <= ge ? (rem_q[k-1] - sh) : rem_q[k-1];
      quo_q[k]  <= quo_q[k-1] | (QB'(ge) << B);
      den_q[k]  <= den_q[k-1];
      over_q[k] <= over_q[k-1];
      neg_q[k]  <= neg_q[k-1];
      nz_q[k]   <= nz_q[k-1];
    end
  end

  // final: floor rounding for negative results, clamp, apply sign
  logic [QB:0]            mag;
  logic signed [QW-1:0]   smag;

  always_comb begin
    if (over_q[QB]) begin
      mag = (QB+1)'(1) << QB;
    end else begin
      mag = {1'b0, quo_q[QB]} + (QB+1)'(neg_q[QB] && (rem_q[QB] != '0));
    end
    smag = QW'(mag);
  end

  always_ff @(posedge clk) begin
    if (nz_q[QB]) begin
      quo <= '0;
    end else begin
      quo <= neg_q[QB] ? -smag : smag;
    end
  end

endmodule

// File: sv/projection_point_transform_top.sv
// Top level: register file, front stages, three divider lanes and output stage.
// One item is accepted every clock cycle (busy never rises) and its result
// strobes out on done after five front stages of multiply,
// add and operand setup, 36 stages of the bit-per-stage quotient pipeline
// (34 quotient bits plus clamp check and sign fix), and one saturation stage.
// Results cannot be held off; the receiver takes each one in its done cycle.
// Matrix registers sit on an APB port at byte addresses 0 to 28 and should
// only be written while no item is in flight.
module projection_point_transform_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  cmd,
  input  logic                        perspective,
  input  logic signed [31:0]          x_in,
  input  logic signed [31:0]          y_in,
  input  logic signed [31:0]          z_in,
  input  logic signed [31:0]          w_in,
  output logic                        done,
  output logic signed [31:0]          x_out,
  output logic signed [31:0]          y_out,
  output logic signed [31:0]          z_out,
  output logic signed [31:0]          w_out,
  output logic                        div_zero,
  output logic                        saturated,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppt_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ppt_pkg::*;

  localparam int NUM_W = DEN_W + FRAC_BITS;
  localparam logic signed [31:0] ONE_CFG = 32'(1) <<< FRAC_BITS;
  localparam logic signed [SV_W-1:0] MAX_V = (SV_W'(1) <<< 31) - SV_W'(1);
  localparam logic signed [SV_W-1:0] MIN_V = -(SV_W'(1) <<< 31);

  ppt_cfg_t cfg;
  ppt_reg_t reg_sel;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_sel = ppt_reg_t'(paddr[ADDR_W-1:2]);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_x  <= ONE_CFG;
      cfg.scale_y  <= ONE_CFG;
      cfg.scale_z  <= ONE_CFG;
      cfg.ratio_x  <= '0;
      cfg.ratio_y  <= '0;
      cfg.offset_x <= '0;
      cfg.offset_y <= '0;
      cfg.offset_z <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_SCALE_X:  cfg.scale_x  <= pwdata;
        REG_SCALE_Y:  cfg.scale_y  <= pwdata;
        REG_SCALE_Z:  cfg.scale_z  <= pwdata;
        REG_RATIO_X:  cfg.ratio_x  <= pwdata;
        REG_RATIO_Y:  cfg.ratio_y  <= pwdata;
        REG_OFFSET_X: cfg.offset_x <= pwdata;
        REG_OFFSET_Y: cfg.offset_y <= pwdata;
        REG_OFFSET_Z: cfg.offset_z <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      REG_SCALE_X:  prdata = cfg.scale_x;
      REG_SCALE_Y:  prdata = cfg.scale_y;
      REG_SCALE_Z:  prdata = cfg.scale_z;
      REG_RATIO_X:  prdata = cfg.ratio_x;
      REG_RATIO_Y:  prdata = cfg.ratio_y;
      REG_OFFSET_X: prdata = cfg.offset_x;
      REG_OFFSET_Y: prdata = cfg.offset_y;
      REG_OFFSET_Z: prdata = cfg.offset_z;
      default:      prdata = '0;
    endcase
  end

  // front stages
  logic             f_valid;
  logic [NUM_W-1:0] f_num [LANES];
  logic [DEN_W-1:0] f_den [LANES];
  logic             f_neg [LANES];
  logic             f_nz [LANES];
  ppt_side_t        f_side;

  ppt_front #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .cmd        (cmd),
    .perspective(perspective),
    .x_in       (x_in),
    .y_in       (y_in),
    .z_in       (z_in),
    .w_in       (w_in),
    .cfg        (cfg),
    .out_valid  (f_valid),
    .lane_num   (f_num),
    .lane_den   (f_den),
    .lane_neg   (f_neg),
    .lane_nzero (f_nz),
    .side       (f_side)
  );

  // divider lanes
  logic signed [QW-1:0] q [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ppt_div #(.NUM_W(NUM_W)) u_div (
      .clk  (clk),
      .num  (f_num[i]),
      .den  (f_den[i]),
      .neg  (f_neg[i]),
      .nzero(f_nz[i]),
      .quo  (q[i])
    );
  end

  // item info and valid bits matched to the divider depth
  logic [DIV_STAGES-1:0] vld_q;
  ppt_side_t             side_q [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STAGES-2:0], f_valid};
    end
    side_q[0] <= f_side;
    for (int k = 1; k < DIV_STAGES; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // output stage: pick source, subtract offset term, saturate
  ppt_side_t              sd;
  logic signed [SV_W-1:0] xv, yv, zv, wv;
  logic [3:0]             ovf;
  logic signed [31:0]     x_next, y_next, z_next, w_next;

  function automatic logic signed [31:0] clamp32(input logic signed [SV_W-1:0] v);
    if (v > MAX_V) begin
      clamp32 = 32'sh7fffffff;
    end else if (v < MIN_V) begin
      clamp32 = 32'sh80000000;
    end else begin
      clamp32 = 32'(v);
    end
  endfunction

  always_comb begin
    sd = side_q[DIV_STAGES-1];
    xv = sd.x_lane ? (SV_W'(q[LANE_X]) - SV_W'(sd.x_sub)) : sd.x_dir;
    yv = sd.y_lane ? (SV_W'(q[LANE_Y]) - SV_W'(sd.y_sub)) : sd.y_dir;
    zv = sd.z_lane ? (SV_W'(q[LANE_Z]) - SV_W'(sd.z_sub)) : sd.z_dir;
    wv = sd.w_lane ? SV_W'(q[LANE_Z]) : sd.w_dir;
    ovf[0] = (xv > MAX_V) || (xv < MIN_V);
    ovf[1] = (yv > MAX_V) || (yv < MIN_V);
    ovf[2] = (zv > MAX_V) || (zv < MIN_V);
    ovf[3] = (wv > MAX_V) || (wv < MIN_V);
    x_next = clamp32(xv);
    y_next = clamp32(yv);
    z_next = clamp32(zv);
    w_next = clamp32(wv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_q[DIV_STAGES-1];
    end
    if (vld_q[DIV_STAGES-1]) begin
      x_out     <= x_next;
      y_out     <= y_next;
      z_out     <= z_next;
      w_out     <= w_next;
      div_zero  <= sd.div_zero;
      saturated <= |ovf;
    end
  end

endmodule

// File: sv/ppt_checker.sv
// Port-level checks for the projection point transform, bound to the top level.
module ppt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [ppt_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                pwdata,
  input logic [31:0]                prdata
);
  import ppt_pkg::*;

  // pipeline is flushed by reset
  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("done strobe right after reset");

  // every accepted item comes out after the fixed latency
  a_item_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted item did not complete on time");

  // no result without an accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching item");

  // a written register reads back its new value
  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite) ##1 (paddr == $past(paddr)) |-> prdata == $past(pwdata))
    else $error("register readback mismatch");

endmodule

bind projection_point_transform_top ppt_checker u_ppt_checker (.*);

// File: verif/projection_point_transform_top_test.sv
// Self-checking testbench for projection_point_transform_top: directed and random items.
module projection_point_transform_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ppt_pkg::*;

  typedef logic signed [127:0] s128_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               dz;
    logic               sat;
  } point_t;

  localparam int           FRAC = 16;
  localparam s128_t        FIX_ONE = s128_t'(1) <<< FRAC;
  localparam s128_t        QUOT_LIM = s128_t'(1) <<< 40;
  localparam logic [31:0]  ONE32 = 32'h0001_0000;
  localparam logic [31:0]  MAX32 = 32'h7fff_ffff;
  localparam logic [31:0]  MIN32 = 32'h8000_0000;
  localparam logic [2:0]   CMD_UNDEF_LO = 3'd5;
  localparam logic [2:0]   CMD_UNDEF_HI = 3'd7;
  localparam int           CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] cmd = '0;
  logic perspective = 1'b0;
  logic signed [31:0] x_in = '0, y_in = '0, z_in = '0, w_in = '0;
  logic done;
  logic signed [31:0] x_out, y_out, z_out, w_out;
  logic div_zero, saturated;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // matrix copy kept by the testbench
  logic signed [31:0] m_sx, m_sy, m_sz, m_rx, m_ry, m_kx, m_ky, m_kz;

  point_t pending_points[$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     gaps_on = 1'b1;

  projection_point_transform_top dut (.*);

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // floor division, quotient bounded so that a later clamp still trips
  function automatic s128_t floor_div(input s128_t n, input s128_t d, inout bit dz);
    s128_t q, r;
    if (d == 0) begin
      dz = 1'b1;
      return (n == 0) ? s128_t'(0) : ((n < 0) ? -QUOT_LIM : QUOT_LIM);
    end
    q = n / d;
    r = n % d;
    if (r != 0 && ((n < 0) != (d < 0))) q = q - 1;
    if (q > QUOT_LIM) q = QUOT_LIM;
    if (q < -QUOT_LIM) q = -QUOT_LIM;
    return q;
  endfunction

  function automatic logic [31:0] clamp32(input s128_t v, inout bit sat);
    if (v > s128_t'(2147483647)) begin
      sat = 1'b1;
      return MAX32;
    end
    if (v < -(s128_t'(1) <<< 31)) begin
      sat = 1'b1;
      return MIN32;
    end
    return v[31:0];
  endfunction

  // expected result of one item under the current matrix
  function automatic point_t project_point(input logic [2:0] c, input logic p,
                                           input logic signed [31:0] xi, yi, zi, wi);
    s128_t x, y, z, w, sx, sy, sz, rx, ry, kx, ky, kz, a, b, d;
    s128_t ox, oy, oz, ow, zr;
    bit dz, sat, zero;
    point_t r;
    x = xi; y = yi; z = zi; w = wi;
    sx = m_sx; sy = m_sy; sz = m_sz; rx = m_rx; ry = m_ry;
    kx = m_kx; ky = m_ky; kz = m_kz;
    zr = 0;
    a = x * FIX_ONE + rx * w;
    b = y * FIX_ONE + ry * w;
    d = z * FIX_ONE + sz * w;
    dz = 1'b0; sat = 1'b0;
    ox = 0; oy = 0; oz = 0; ow = 0;
    if ((c == CMD_PROJ_DIV || c == CMD_PROJ_HOM) && !p) begin
      ox = (sx * x + kx * FIX_ONE) >>> FRAC;
      oy = (sy * y + ky * FIX_ONE) >>> FRAC;
      oz = (sz * z + kz * FIX_ONE) >>> FRAC;
      ow = (c == CMD_PROJ_HOM) ? FIX_ONE : zr;
    end else if (c == CMD_PROJ_DIV) begin
      ox = floor_div(-(sx * x), z, dz) - rx;
      oy = floor_div(-(sy * y), z, dz) - ry;
      oz = floor_div(-(kz * FIX_ONE), z, dz) - sz;
    end else if (c == CMD_PROJ_HOM) begin
      ox = (sx * x + rx * z) >>> FRAC;
      oy = (sy * y + ry * z) >>> FRAC;
      oz = (kz * FIX_ONE + sz * z) >>> FRAC;
      ow = -z;
    end else if (c == CMD_DEPTH_UNPROJ) begin
      if (p) oz = floor_div(-(kz * FIX_ONE), z + sz, dz);
      else oz = floor_div((z - kz) * FIX_ONE, sz, dz);
    end else if ((c == CMD_HOM_UNPROJ || c == CMD_UNPROJ_PT) && !p) begin
      zero = (c == CMD_HOM_UNPROJ) && (sx == 0 || sy == 0 || sz == 0);
      ox = floor_div((x - kx) * FIX_ONE, zero ? zr : sx, dz);
      oy = floor_div((y - ky) * FIX_ONE, zero ? zr : sy, dz);
      oz = floor_div((z - kz) * FIX_ONE, zero ? zr : sz, dz);
      ow = (c == CMD_HOM_UNPROJ) ? FIX_ONE : zr;
    end else if (c == CMD_HOM_UNPROJ) begin
      zero = sx == 0 || sy == 0 || kz == 0;
      ox = floor_div(a, zero ? zr : sx, dz);
      oy = floor_div(b, zero ? zr : sy, dz);
      oz = -w;
      ow = floor_div(d, zero ? zr : kz, dz);
    end else if (c == CMD_UNPROJ_PT) begin
      zero = sx == 0 || sy == 0 || d == 0;
      ox = floor_div((kz * a) <<< FRAC, zero ? zr : sx * d, dz);
      oy = floor_div((kz * b) <<< FRAC, zero ? zr : sy * d, dz);
      oz = floor_div((kz * -w) <<< FRAC, zero ? zr : d, dz);
    end
    r.x = clamp32(ox, sat);
    r.y = clamp32(oy, sat);
    r.z = clamp32(oz, sat);
    r.w = clamp32(ow, sat);
    r.dz = dz;
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got, exp);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", field, got, exp, cycles);
    mismatches++;
  endtask

  // compare each result with the oldest expected point
  always @(negedge clk) begin
    point_t e;
    if (!rst && done) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected result", x_out, '0);
      end else begin
        e = pending_points.pop_front();
        if (x_out !== e.x) report_mismatch("x_out", x_out, e.x);
        if (y_out !== e.y) report_mismatch("y_out", y_out, e.y);
        if (z_out !== e.z) report_mismatch("z_out", z_out, e.z);
        if (w_out !== e.w) report_mismatch("w_out", w_out, e.w);
        if (div_zero !== e.dz) report_mismatch("div_zero", div_zero, e.dz);
        if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
      end
    end
  end

  // send one item; start stays high so that a following item goes back to back, unless a random gap is inserted
  task automatic send_item(input logic [2:0] c, input logic p,
                           input logic signed [31:0] xi, yi, zi, wi);
    start <= 1'b1;
    cmd <= c;
    perspective <= p;
    x_in <= xi; y_in <= yi; z_in <= zi; w_in <= wi;
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_points.push_back(project_point(c, p, xi, yi, zi, wi));
    if (gaps_on && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // let every item in flight come out
  task automatic drain;
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input ppt_reg_t r, input logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      REG_SCALE_X:  m_sx = v;
      REG_SCALE_Y:  m_sy = v;
      REG_SCALE_Z:  m_sz = v;
      REG_RATIO_X:  m_rx = v;
      REG_RATIO_Y:  m_ry = v;
      REG_OFFSET_X: m_kx = v;
      REG_OFFSET_Y: m_ky = v;
      default:      m_kz = v;
    endcase
  endtask

  task automatic write_matrix(input logic [31:0] sx, sy, sz, rx, ry, kx, ky, kz);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_SCALE_Z, sz);
    write_reg(REG_RATIO_X, rx);
    write_reg(REG_RATIO_Y, ry);
    write_reg(REG_OFFSET_X, kx);
    write_reg(REG_OFFSET_Y, ky);
    write_reg(REG_OFFSET_Z, kz);
  endtask

  // value mix: near unity, full range, extremes, zero
  function automatic logic [31:0] rand_fix();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      4, 5:       return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      6, 7:       return $urandom;
      8:          return ($urandom_range(0, 1) != 0) ? MAX32 : MIN32;
      default:    return ($urandom_range(0, 1) != 0) ? ONE32 : 32'd0;
    endcase
  endfunction

  function automatic logic [2:0] rand_cmd();
    if ($urandom_range(0, 19) == 0) return 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
    return 3'($urandom_range(CMD_PROJ_DIV, CMD_UNPROJ_PT));
  endfunction

  // every command in both modes on the reset matrix, plus undefined commands
  task automatic test_commands;
    for (int c = 0; c <= 7; c++)
      for (int p = 0; p <= 1; p++)
        send_item(3'(c), 1'(p), 32'sh0001_8000, -32'sh0002_4000, 32'sh0003_0000,
                  32'sh0000_c000);
  endtask

  // field extremes and the zero divisor cases of each command
  task automatic test_edges;
    write_matrix(ONE32 * 2, ONE32, ONE32, 32'h0000_4000, 32'hffff_c000, ONE32, 32'd0,
                 ONE32 * 3);
    send_item(CMD_PROJ_DIV, 1'b1, MAX32, MIN32, 32'sd0, 32'sd0);
    send_item(CMD_PROJ_DIV, 1'b0, MAX32, MIN32, MIN32, MAX32);
    send_item(CMD_PROJ_HOM, 1'b1, MIN32, MAX32, MIN32, MIN32);
    send_item(CMD_DEPTH_UNPROJ, 1'b1, 32'sd0, 32'sd0, -32'sh0001_0000, 32'sd0);
    send_item(CMD_HOM_UNPROJ, 1'b1, MAX32, MAX32, MAX32, MIN32);
    send_item(CMD_UNPROJ_PT, 1'b1, ONE32, ONE32, -32'sh0001_0000, ONE32);
    send_item(CMD_UNPROJ_PT, 1'b1, MIN32, MAX32, MAX32, MAX32);
    drain();
    // zero x and z scales and zero depth offset
    write_matrix(32'd0, ONE32, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    for (int c = CMD_PROJ_DIV; c <= CMD_UNPROJ_PT; c++)
      for (int p = 0; p <= 1; p++)
        send_item(3'(c), 1'(p), ONE32, 32'sd0, ONE32, ONE32);
    drain();
    // matrix at both extremes
    write_matrix(MAX32, MAX32, MAX32, MAX32, MAX32, MAX32, MAX32, MAX32);
    for (int c = CMD_PROJ_DIV; c <= CMD_UNPROJ_PT; c++)
      send_item(3'(c), 1'($urandom_range(0, 1)), MAX32, MIN32, MAX32, ONE32);
    drain();
    write_matrix(MIN32, MIN32, MIN32, MIN32, MIN32, MIN32, MIN32, MIN32);
    for (int c = CMD_PROJ_DIV; c <= CMD_UNPROJ_PT; c++)
      send_item(3'(c), 1'($urandom_range(0, 1)), MIN32, MIN32, MIN32, MIN32);
    drain();
  endtask

  // random matrices, each followed by a stream of random items
  task automatic test_random_streams;
    for (int phase = 0; phase < 8; phase++) begin
      write_matrix(rand_fix(), rand_fix(), rand_fix(), rand_fix(), rand_fix(), rand_fix(),
                   rand_fix(), rand_fix());
      gaps_on = (phase != 2);
      for (int i = 0; i < 62; i++) begin
        send_item(rand_cmd(), 1'($urandom_range(0, 1)), rand_fix(), rand_fix(), rand_fix(),
                  rand_fix());
        // hold off once until the pipeline has emptied
        if (phase == 4 && i == 30) drain();
      end
      drain();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    m_sx = ONE32; m_sy = ONE32; m_sz = ONE32;
    m_rx = '0; m_ry = '0; m_kx = '0; m_ky = '0; m_kz = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_commands();
    drain();
    test_edges();
    test_random_streams();
    drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
